FILE: rtl/image_upscale_bilinear_top_defines.svh
// Assertion macros for the bilinear upscaler top level.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef IMAGE_UPSCALE_BILINEAR_TOP_DEFINES_SVH
`define IMAGE_UPSCALE_BILINEAR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IUB_CHECK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("image_upscale_bilinear: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IUB_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("image_upscale_bilinear: next-cycle check failed");

`endif

FILE: rtl/iub_pkg.sv
// Shared constants, types and codes for the bilinear upscaler.
// Used by every module of the block but iub_ram; depends on nothing else.
`default_nettype none

package iub_pkg;

	// Image geometry and fixed-point format.
	localparam int SRC_HEIGHT = 60;
	localparam int SRC_WIDTH  = 94;
	localparam int DST_HEIGHT = 120;
	localparam int DST_WIDTH  = 188;
	localparam int FRAC_BITS  = 8;

	// Field widths of the item ports.
	localparam int IDX_W = 13;
	localparam int PIX_W = 8;
	localparam int ROW_W = 7;
	localparam int COL_W = 8;

	localparam int PIX_COUNT = SRC_HEIGHT * SRC_WIDTH;

	// Source step per output pixel on each axis.
	localparam int STEP_Y   = (SRC_HEIGHT << FRAC_BITS) / DST_HEIGHT;
	localparam int STEP_X   = (SRC_WIDTH << FRAC_BITS) / DST_WIDTH;
	localparam int STEP_Y_W = $clog2(STEP_Y + 1);
	localparam int STEP_X_W = $clog2(STEP_X + 1);
	localparam int POS_Y_W  = ROW_W + STEP_Y_W;
	localparam int POS_X_W  = COL_W + STEP_X_W;
	localparam int YI_W     = $clog2(SRC_HEIGHT);
	localparam int XI_W     = $clog2(SRC_WIDTH);
	localparam int WGT_W    = FRAC_BITS + 1;

	// The source image is split into four banks by row and column parity,
	// so the four taps of one query always fall into different banks.
	localparam int NUM_BANKS  = 4;
	localparam int BANK_H     = (SRC_HEIGHT + 1) / 2;
	localparam int BANK_W     = (SRC_WIDTH + 1) / 2;
	localparam int BANK_DEPTH = BANK_H * BANK_W;
	localparam int BADDR_W    = $clog2(BANK_DEPTH);
	localparam int BROW_W     = (BANK_H > 1) ? $clog2(BANK_H) : 1;
	localparam int BCOL_W     = (BANK_W > 1) ? $clog2(BANK_W) : 1;

	// Reciprocal of the source width for splitting a load index.
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP       = (1 << RECIP_SHIFT) / SRC_WIDTH;
	localparam int RECIP_W     = $clog2(RECIP + 1);

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Interpolation sums.
	localparam int A_W = PIX_W + FRAC_BITS;
	localparam int V_W = PIX_W + 2 * FRAC_BITS;

	// Request codes.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// One decoded item as it waits between the front and the back.
	typedef struct packed {
		logic                                is_query;
		logic [NUM_BANKS-1:0]                wr_en;
		logic [PIX_W-1:0]                    wdata;
		logic [NUM_BANKS-1:0][BADDR_W-1:0]   addr;
		logic                                y_odd;
		logic                                x_odd;
		logic [FRAC_BITS-1:0]                fy;
		logic [FRAC_BITS-1:0]                fx;
		logic [ROW_W-1:0]                    row;
		logic [COL_W-1:0]                    col;
	} iub_entry_t;

	typedef struct packed {
		logic       valid;
		iub_entry_t entry;
	} iub_item_t;

endpackage

`default_nettype wire

FILE: rtl/iub_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the source image banks.
`default_nettype none

module iub_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/iub_front.sv
// Front of the upscaler: accepts items, splits load indexes into bank
// addresses and turns queries into tap addresses and weights. Uses iub_pkg.
`default_nettype none

module iub_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       req_type,
	input  logic [iub_pkg::IDX_W-1:0]  load_index,
	input  logic [iub_pkg::PIX_W-1:0]  pixel_value,
	input  logic [iub_pkg::ROW_W-1:0]  out_row,
	input  logic [iub_pkg::COL_W-1:0]  out_col,
	input  logic [iub_pkg::QCNT_W-1:0] level,
	output iub_pkg::iub_item_t         push
);

	import iub_pkg::*;

	logic                            accept;
	logic [QCNT_W:0]                 occupancy;
	logic [IDX_W+RECIP_W-1:0]        prod;

	// Stage 1
	logic                            v_s1;
	logic                            query_s1;
	logic                            inrange_s1;
	logic [IDX_W-1:0]                li_s1;
	logic [IDX_W-1:0]                rest_s1;
	logic [PIX_W-1:0]                pv_s1;
	logic [POS_Y_W-1:0]              posy_s1;
	logic [POS_X_W-1:0]              posx_s1;
	logic [ROW_W-1:0]                row_s1;
	logic [COL_W-1:0]                col_s1;

	// Stage 2 inputs and registers
	logic [NUM_BANKS-1:0]            wr_en_n;
	logic [BROW_W-1:0]               brow_e_n;
	logic [BROW_W-1:0]               brow_o_n;
	logic [BCOL_W-1:0]               bcol_e_n;
	logic [BCOL_W-1:0]               bcol_o_n;
	logic [YI_W-1:0]                 yi_n;
	logic [XI_W-1:0]                 xi_n;

	logic                            v_s2;
	logic                            query_s2;
	logic [NUM_BANKS-1:0]            wr_en_s2;
	logic [PIX_W-1:0]                pv_s2;
	logic [BROW_W-1:0]               brow_e_s2;
	logic [BROW_W-1:0]               brow_o_s2;
	logic [BCOL_W-1:0]               bcol_e_s2;
	logic [BCOL_W-1:0]               bcol_o_s2;
	logic                            y_odd_s2;
	logic                            x_odd_s2;
	logic [FRAC_BITS-1:0]            fy_s2;
	logic [FRAC_BITS-1:0]            fx_s2;
	logic [ROW_W-1:0]                row_s2;
	logic [COL_W-1:0]                col_s2;

	// Stage 3
	logic [NUM_BANKS-1:0][BADDR_W-1:0] addr_n;
	logic                            v_s3;
	iub_entry_t                      entry_s3;

	// Every item in flight in the front has a queue slot reserved for it.
	assign occupancy = (QCNT_W+1)'(level) + (QCNT_W+1)'(v_s1) + (QCNT_W+1)'(v_s2)
		+ (QCNT_W+1)'(v_s3);
	assign req_stall = occupancy >= (QCNT_W+1)'(QUEUE_DEPTH);
	assign accept    = req_valid && !req_stall;

	assign prod = (IDX_W+RECIP_W)'(load_index) * (IDX_W+RECIP_W)'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		query_s1   <= (req_type == REQ_QUERY);
		inrange_s1 <= 32'(load_index) < 32'(PIX_COUNT);
		li_s1      <= load_index;
		rest_s1    <= IDX_W'(prod >> RECIP_SHIFT);
		pv_s1      <= pixel_value;
		posy_s1    <= POS_Y_W'(out_row) * POS_Y_W'(STEP_Y);
		posx_s1    <= POS_X_W'(out_col) * POS_X_W'(STEP_X);
		row_s1     <= out_row;
		col_s1     <= out_col;
	end

	// The row estimate from the reciprocal is exact or one short.
	always_comb begin
		logic [IDX_W-1:0]   rw_prod;
		logic [IDX_W-1:0]   crem;
		logic [IDX_W-1:0]   lrow;
		logic [IDX_W-1:0]   lcol;
		logic [1:0]         lbank;
		logic [POS_Y_W-FRAC_BITS-1:0] ipy;
		logic [POS_X_W-FRAC_BITS-1:0] ipx;
		logic [YI_W:0]      yi1;
		logic [XI_W:0]      xi1;

		rw_prod = IDX_W'(rest_s1 * IDX_W'(SRC_WIDTH));
		crem    = li_s1 - rw_prod;
		if (crem >= IDX_W'(SRC_WIDTH)) begin
			lrow = rest_s1 + IDX_W'(1);
			lcol = crem - IDX_W'(SRC_WIDTH);
		end else begin
			lrow = rest_s1;
			lcol = crem;
		end
		lbank = {lrow[0], lcol[0]};

		ipy = posy_s1[POS_Y_W-1:FRAC_BITS];
		ipx = posx_s1[POS_X_W-1:FRAC_BITS];
		if (32'(ipy) >= 32'(SRC_HEIGHT - 1)) begin
			yi_n = YI_W'(SRC_HEIGHT - 2);
		end else begin
			yi_n = YI_W'(ipy);
		end
		if (32'(ipx) >= 32'(SRC_WIDTH - 1)) begin
			xi_n = XI_W'(SRC_WIDTH - 2);
		end else begin
			xi_n = XI_W'(ipx);
		end
		yi1 = (YI_W+1)'(yi_n) + (YI_W+1)'(1);
		xi1 = (XI_W+1)'(xi_n) + (XI_W+1)'(1);

		if (query_s1) begin
			wr_en_n  = '0;
			brow_e_n = BROW_W'(yi1 >> 1);
			brow_o_n = BROW_W'(yi_n >> 1);
			bcol_e_n = BCOL_W'(xi1 >> 1);
			bcol_o_n = BCOL_W'(xi_n >> 1);
		end else begin
			wr_en_n  = inrange_s1 ? (NUM_BANKS'(1) << lbank) : '0;
			brow_e_n = BROW_W'(lrow >> 1);
			brow_o_n = BROW_W'(lrow >> 1);
			bcol_e_n = BCOL_W'(lcol >> 1);
			bcol_o_n = BCOL_W'(lcol >> 1);
		end
	end

	always_ff @(posedge clk) begin
		query_s2  <= query_s1;
		wr_en_s2  <= wr_en_n;
		pv_s2     <= pv_s1;
		brow_e_s2 <= brow_e_n;
		brow_o_s2 <= brow_o_n;
		bcol_e_s2 <= bcol_e_n;
		bcol_o_s2 <= bcol_o_n;
		y_odd_s2  <= yi_n[0];
		x_odd_s2  <= xi_n[0];
		fy_s2     <= posy_s1[FRAC_BITS-1:0];
		fx_s2     <= posx_s1[FRAC_BITS-1:0];
		row_s2    <= row_s1;
		col_s2    <= col_s1;
	end

	// Bank k holds rows of parity k[1] and columns of parity k[0].
	always_comb begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			addr_n[k] = BADDR_W'((k / 2 == 1 ? brow_o_s2 : brow_e_s2) * BADDR_W'(BANK_W))
				+ BADDR_W'(k % 2 == 1 ? bcol_o_s2 : bcol_e_s2);
		end
	end

	always_ff @(posedge clk) begin
		entry_s3.is_query <= query_s2;
		entry_s3.wr_en    <= wr_en_s2;
		entry_s3.wdata    <= pv_s2;
		entry_s3.addr     <= addr_n;
		entry_s3.y_odd    <= y_odd_s2;
		entry_s3.x_odd    <= x_odd_s2;
		entry_s3.fy       <= fy_s2;
		entry_s3.fx       <= fx_s2;
		entry_s3.row      <= row_s2;
		entry_s3.col      <= col_s2;
	end

	assign push.valid = v_s3;
	assign push.entry = entry_s3;

endmodule

`default_nettype wire

FILE: rtl/iub_queue.sv
// Short queue of decoded items between the front and the back.
// Uses iub_pkg for the entry type and depth.
`default_nettype none

module iub_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  iub_pkg::iub_item_t         push,
	input  logic                       pop,
	output iub_pkg::iub_item_t         head,
	output logic [iub_pkg::QCNT_W-1:0] level
);

	import iub_pkg::*;

	iub_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] level_q;
	logic              do_pop;

	assign head.valid = (level_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign level      = level_q;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	// The front never pushes without a free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push.valid, do_pop})
				2'b10:   level_q <= level_q + QCNT_W'(1);
				2'b01:   level_q <= level_q - QCNT_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/iub_back.sv
// Back of the upscaler: writes loads into the four image banks, reads the
// four taps of a query and interpolates. Uses iub_pkg and iub_ram.
`default_nettype none

module iub_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  iub_pkg::iub_item_t        head,
	output logic                      pop,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [iub_pkg::PIX_W-1:0] result_pixel,
	output logic [iub_pkg::ROW_W-1:0] result_row,
	output logic [iub_pkg::COL_W-1:0] result_col
);

	import iub_pkg::*;

	logic                 adv;
	logic [PIX_W-1:0]     rdata [NUM_BANKS];

	logic                 v_s1;
	logic                 y_odd_s1;
	logic                 x_odd_s1;
	logic [FRAC_BITS-1:0] fy_s1;
	logic [FRAC_BITS-1:0] fx_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [COL_W-1:0]     col_s1;

	logic [A_W-1:0]       a_n;
	logic [A_W-1:0]       b_n;
	logic                 v_s2;
	logic [A_W-1:0]       a_s2;
	logic [A_W-1:0]       b_s2;
	logic [FRAC_BITS-1:0] fy_s2;
	logic [ROW_W-1:0]     row_s2;
	logic [COL_W-1:0]     col_s2;

	logic [V_W-1:0]       sum_n;
	logic                 v_s3;
	logic [V_W-1:0]       sum_s3;
	logic [ROW_W-1:0]     row_s3;
	logic [COL_W-1:0]     col_s3;

	logic [V_W:0]         rounded;
	logic                 res_valid_q;
	logic [PIX_W-1:0]     result_pixel_q;
	logic [ROW_W-1:0]     result_row_q;
	logic [COL_W-1:0]     result_col_q;

	// The whole back moves together whenever the output register can take an item.
	assign adv = !res_valid_q || !res_stall;
	assign pop = head.valid && adv;

	for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
		iub_ram #(
			.WIDTH(PIX_W),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (pop && head.entry.wr_en[k]),
			.waddr(head.entry.addr[k]),
			.wdata(head.entry.wdata),
			.re   (adv),
			.raddr(head.entry.addr[k]),
			.rdata(rdata[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop && head.entry.is_query;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			res_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_odd_s1 <= head.entry.y_odd;
			x_odd_s1 <= head.entry.x_odd;
			fy_s1    <= head.entry.fy;
			fx_s1    <= head.entry.fx;
			row_s1   <= head.entry.row;
			col_s1   <= head.entry.col;
		end
	end

	// Horizontal blend of the upper and lower tap pairs.
	always_comb begin
		logic [PIX_W-1:0] p00;
		logic [PIX_W-1:0] p01;
		logic [PIX_W-1:0] p10;
		logic [PIX_W-1:0] p11;
		logic [WGT_W-1:0] wx;

		p00 = rdata[{y_odd_s1, x_odd_s1}];
		p01 = rdata[{y_odd_s1, !x_odd_s1}];
		p10 = rdata[{!y_odd_s1, x_odd_s1}];
		p11 = rdata[{!y_odd_s1, !x_odd_s1}];
		wx  = WGT_W'(1 << FRAC_BITS) - WGT_W'(fx_s1);
		a_n = A_W'((A_W+1)'(p00) * (A_W+1)'(wx) + (A_W+1)'(p01) * (A_W+1)'(fx_s1));
		b_n = A_W'((A_W+1)'(p10) * (A_W+1)'(wx) + (A_W+1)'(p11) * (A_W+1)'(fx_s1));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2   <= a_n;
			b_s2   <= b_n;
			fy_s2  <= fy_s1;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
		end
	end

	always_comb begin
		logic [WGT_W-1:0] wy;

		wy    = WGT_W'(1 << FRAC_BITS) - WGT_W'(fy_s2);
		sum_n = V_W'((V_W+1)'(a_s2) * (V_W+1)'(wy) + (V_W+1)'(b_s2) * (V_W+1)'(fy_s2));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sum_n;
			row_s3 <= row_s2;
			col_s3 <= col_s2;
		end
	end

	assign rounded = (V_W+1)'(sum_s3) + (V_W+1)'(1 << (2 * FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		if (adv) begin
			result_pixel_q <= rounded[2*FRAC_BITS +: PIX_W];
			result_row_q   <= row_s3;
			result_col_q   <= col_s3;
		end
	end

	assign res_valid    = res_valid_q;
	assign result_pixel = result_pixel_q;
	assign result_row   = result_row_q;
	assign result_col   = result_col_q;

endmodule

`default_nettype wire

FILE: rtl/image_upscale_bilinear_top.sv
// Bilinear image upscaler, top level.
// Request channel (req_valid / req_stall): a load item (req_type 0) writes
// pixel_value into the source image at load_index; an index past the image
// is dropped. A query item (req_type 1) asks for output pixel out_row,
// out_col and returns one result item; a load returns none.
// Result channel (res_valid / res_stall): result_pixel with the echoed row
// and column, in the order the queries were taken.
// Throughput is one item per clock on both channels unless stalled. A query
// reads its four taps together from four RAM banks split by row and column
// parity. A query passes the front stages, the queue and the back to res_valid.
// When the receiver stalls, the result holds and the back pipeline freezes;
// the front keeps taking items until the items in its three stages and in
// the queue together reach the queue depth of 8, then raises req_stall.
// Reset clears all control state; the source image is not cleared, and a
// pixel must be loaded before a query reads it.
`default_nettype none
`include "image_upscale_bilinear_top_defines.svh"

module image_upscale_bilinear_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic                      req_type,
	input  logic [iub_pkg::IDX_W-1:0] load_index,
	input  logic [iub_pkg::PIX_W-1:0] pixel_value,
	input  logic [iub_pkg::ROW_W-1:0] out_row,
	input  logic [iub_pkg::COL_W-1:0] out_col,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [iub_pkg::PIX_W-1:0] result_pixel,
	output logic [iub_pkg::ROW_W-1:0] result_row,
	output logic [iub_pkg::COL_W-1:0] result_col
);

	import iub_pkg::*;

	iub_item_t         push;
	iub_item_t         head;
	logic              pop;
	logic [QCNT_W-1:0] level;

	iub_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.load_index (load_index),
		.pixel_value(pixel_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.level      (level),
		.push       (push)
	);

	iub_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.level (level)
	);

	iub_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.result_pixel(result_pixel),
		.result_row  (result_row),
		.result_col  (result_col)
	);

	`IUB_CHECK_NOW(a_queue_room, push.valid, level < QCNT_W'(QUEUE_DEPTH))
	`IUB_CHECK_NOW(a_pop_nonempty, pop, head.valid)
	`IUB_CHECK_NOW(a_one_bank_write, push.valid, $onehot0(push.entry.wr_en))
	`IUB_CHECK_NOW(a_query_no_write, push.valid && push.entry.is_query, push.entry.wr_en == '0)
	`IUB_CHECK_NEXT(a_push_lands, push.valid, head.valid)

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the bilinear upscaler: loads source pixels, queries output
// pixels and compares every result against an in-bench interpolation or a table value.
// Depends on iub_pkg and image_upscale_bilinear_top only.

module tb_top;
	import iub_pkg::*;

	localparam int FRAC         = FRAC_BITS;
	localparam int ONE          = 1 << FRAC;
	localparam int LATENCY      = 7;
	localparam int RANDOM_ITEMS = 550;
	localparam int LONG_HOLD    = 60;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_PRINTS   = 100;
	localparam int DIR_N        = 23;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  idx;
		logic [PIX_W-1:0]  val;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              typed;
		logic [PIX_W-1:0]  pixel;
	} stim_row_t;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pixel_expect_t;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	logic             req_type;
	logic [IDX_W-1:0] load_index;
	logic [PIX_W-1:0] pixel_value;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic             res_valid;
	logic             res_stall;
	logic [PIX_W-1:0] result_pixel;
	logic [ROW_W-1:0] result_row;
	logic [COL_W-1:0] result_col;

	logic [PIX_W-1:0] src_img    [PIX_COUNT];
	bit               src_loaded [PIX_COUNT];
	pixel_expect_t    pending_pixels [$];

	int  send_idle_pct = 38;
	int  recv_idle_pct = 63;
	bit  hold_req      = 1'b0;
	int  hold_left     = 0;
	int  cycle_count   = 0;
	int  n_sent        = 0;
	int  n_loads       = 0;
	int  n_dropped     = 0;
	int  n_queries     = 0;
	int  n_results     = 0;
	int  n_backpress   = 0;
	int  n_errors      = 0;

	// The two corner neighborhoods are written at both brightness extremes, and
	// loads past the end of the image must leave them untouched.
	stim_row_t dir_tbl [0:DIR_N-1] = '{
		'{REQ_LOAD,  13'd0,    8'd255, 7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_LOAD,  13'd1,    8'd255, 7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_LOAD,  13'd94,   8'd255, 7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_LOAD,  13'd95,   8'd255, 7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_QUERY, 13'd0,    8'd0,   7'd0,   8'd0,   1'b1, 8'd255},
		'{REQ_LOAD,  13'd5544, 8'd255, 7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_LOAD,  13'd5545, 8'd255, 7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_LOAD,  13'd5638, 8'd255, 7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_LOAD,  13'd5639, 8'd255, 7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_QUERY, 13'd0,    8'd0,   7'd119, 8'd187, 1'b1, 8'd255},
		'{REQ_QUERY, 13'd8191, 8'd255, 7'd127, 8'd255, 1'b1, 8'd255},
		'{REQ_LOAD,  13'd5640, 8'd0,   7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_LOAD,  13'd8191, 8'd0,   7'd127, 8'd255, 1'b0, 8'd0},
		'{REQ_QUERY, 13'd0,    8'd0,   7'd0,   8'd0,   1'b1, 8'd255},
		'{REQ_QUERY, 13'd0,    8'd0,   7'd119, 8'd187, 1'b1, 8'd255},
		'{REQ_LOAD,  13'd0,    8'd0,   7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_LOAD,  13'd1,    8'd0,   7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_LOAD,  13'd94,   8'd0,   7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_LOAD,  13'd95,   8'd0,   7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_QUERY, 13'd0,    8'd0,   7'd0,   8'd0,   1'b1, 8'd0},
		'{REQ_LOAD,  13'd5639, 8'd0,   7'd0,   8'd0,   1'b0, 8'd0},
		'{REQ_QUERY, 13'd0,    8'd0,   7'd119, 8'd187, 1'b0, 8'd0},
		'{REQ_QUERY, 13'd0,    8'd0,   7'd0,   8'd1,   1'b0, 8'd0}
	};

	image_upscale_bilinear_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.load_index   (load_index),
		.pixel_value  (pixel_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_pixel (result_pixel),
		.result_row   (result_row),
		.result_col   (result_col)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Source position of an output coordinate: the upper-left tap, clamped so
	// that its neighbor stays inside the image, and the fraction that weights it.
	function automatic void split_coord(input int unsigned coord, input int unsigned src_n,
			input int unsigned dst_n, output int unsigned tap, output int unsigned frac);
		int unsigned pos;
		pos = coord * ((src_n << FRAC) / dst_n);
		tap = pos >> FRAC;
		if (tap >= src_n - 1)
			tap = src_n - 2;
		frac = pos & (ONE - 1);
	endfunction

	function automatic logic [PIX_W-1:0] interp_pixel(input int unsigned row,
			input int unsigned col);
		int unsigned ty, fy, tx, fx, base, top, bot, acc;
		split_coord(row, SRC_HEIGHT, DST_HEIGHT, ty, fy);
		split_coord(col, SRC_WIDTH, DST_WIDTH, tx, fx);
		base = ty * SRC_WIDTH + tx;
		top = src_img[base] * (ONE - fx) + src_img[base + 1] * fx;
		bot = src_img[base + SRC_WIDTH] * (ONE - fx) + src_img[base + SRC_WIDTH + 1] * fx;
		acc = top * (ONE - fy) + bot * fy + (1 << (2 * FRAC - 1));
		return PIX_W'(acc >> (2 * FRAC));
	endfunction

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	// Offers one item from the next falling edge on and returns at the rising
	// edge that accepts it. Idle cycles carry random junk with valid low.
	task automatic offer_item(input logic kind, input int unsigned idx, input int unsigned val,
			input int unsigned row, input int unsigned col, input bit typed,
			input int unsigned typed_pix);
		pixel_expect_t want;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid   <= 1'b0;
			req_type    <= ($urandom_range(0, 1) != 0);
			load_index  <= IDX_W'($urandom);
			pixel_value <= PIX_W'($urandom);
			out_row     <= ROW_W'($urandom);
			out_col     <= COL_W'($urandom);
			@(negedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= kind;
		load_index  <= IDX_W'(idx);
		pixel_value <= PIX_W'(val);
		out_row     <= ROW_W'(row);
		out_col     <= COL_W'(col);
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		n_sent++;
		if (kind == REQ_LOAD) begin
			n_loads++;
			if (idx < PIX_COUNT) begin
				src_img[idx]    = PIX_W'(val);
				src_loaded[idx] = 1'b1;
			end else begin
				n_dropped++;
			end
		end else begin
			n_queries++;
			want.pixel = typed ? PIX_W'(typed_pix) : interp_pixel(row, col);
			want.row   = ROW_W'(row);
			want.col   = COL_W'(col);
			pending_pixels.push_back(want);
		end
	endtask

	// Loads whichever of the four taps are still unwritten, then queries.
	task automatic query_with_taps(input int unsigned row, input int unsigned col);
		int unsigned ty, fy, tx, fx, idx;
		split_coord(row, SRC_HEIGHT, DST_HEIGHT, ty, fy);
		split_coord(col, SRC_WIDTH, DST_WIDTH, tx, fx);
		for (int k = 0; k < 4; k++) begin
			idx = (ty + k / 2) * SRC_WIDTH + tx + k % 2;
			if (!src_loaded[idx])
				offer_item(REQ_LOAD, idx, $urandom_range(0, 255), $urandom_range(0, 127),
					$urandom_range(0, 255), 1'b0, 0);
		end
		offer_item(REQ_QUERY, $urandom_range(0, (1 << IDX_W) - 1), $urandom_range(0, 255),
			row, col, 1'b0, 0);
	endtask

	// Result side: random stall, or one long hold-off when asked for.
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && req_stall)
			n_backpress++;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: row %0d col %0d pixel %0d",
					result_row, result_col, result_pixel));
			end else begin
				if (result_pixel !== pending_pixels[0].pixel)
					report_mismatch($sformatf("pixel %0d, want %0d (row %0d col %0d)",
						result_pixel, pending_pixels[0].pixel, pending_pixels[0].row,
						pending_pixels[0].col));
				if (result_row !== pending_pixels[0].row)
					report_mismatch($sformatf("row %0d, want %0d", result_row,
						pending_pixels[0].row));
				if (result_col !== pending_pixels[0].col)
					report_mismatch($sformatf("col %0d, want %0d", result_col,
						pending_pixels[0].col));
				void'(pending_pixels.pop_front());
				n_results++;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
			pending_pixels.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		int prog;
		int phase;
		int pick;
		bit hold_done;
		hold_done   = 1'b0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req_type    = REQ_LOAD;
		load_index  = '0;
		pixel_value = '0;
		out_row     = '0;
		out_col     = '0;
		for (int i = 0; i < PIX_COUNT; i++) begin
			src_img[i]    = '0;
			src_loaded[i] = 1'b0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++)
			offer_item(dir_tbl[i].kind, dir_tbl[i].idx, dir_tbl[i].val, dir_tbl[i].row,
				dir_tbl[i].col, dir_tbl[i].typed, dir_tbl[i].pixel);

		while (n_sent < DIR_N + RANDOM_ITEMS) begin
			prog  = n_sent - DIR_N;
			phase = (3 * prog) / RANDOM_ITEMS;
			if (phase == 0) begin
				send_idle_pct = 38;
				recv_idle_pct = 63;
			end else if (phase == 1) begin
				send_idle_pct = 63;
				recv_idle_pct = 38;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				// Hold results off while items keep coming, so the input backs up.
				if (!hold_done) begin
					hold_req  = 1'b1;
					hold_done = 1'b1;
				end
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				query_with_taps($urandom_range(0, DST_HEIGHT - 1),
					$urandom_range(0, DST_WIDTH - 1));
			end else if (pick < 68) begin
				// Anywhere the field widths reach, past the output edges included.
				query_with_taps($urandom_range(0, (1 << ROW_W) - 1),
					$urandom_range(0, (1 << COL_W) - 1));
			end else if (pick < 85) begin
				offer_item(REQ_LOAD, $urandom_range(0, PIX_COUNT - 1), $urandom_range(0, 255),
					$urandom_range(0, 127), $urandom_range(0, 255), 1'b0, 0);
			end else if (pick < 93) begin
				offer_item(REQ_LOAD, $urandom_range(PIX_COUNT, (1 << IDX_W) - 1),
					$urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 255),
					1'b0, 0);
			end else begin
				query_with_taps(($urandom_range(0, 1) != 0) ? 0 :
					$urandom_range(DST_HEIGHT - 1, (1 << ROW_W) - 1),
					($urandom_range(0, 1) != 0) ? 0 :
					$urandom_range(DST_WIDTH - 1, (1 << COL_W) - 1));
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);

		$display("Sent %0d loads (%0d past the image) and %0d queries; checked %0d results.",
			n_loads, n_dropped, n_queries, n_results);
		$display("Input was held off for %0d cycles, with one result hold of %0d cycles.",
			n_backpress, LONG_HOLD);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
